>>> hw/rtl/rle_sprite_stream_decoder_unit_assert.svh
// Assertion macros for the sprite stream decoder unit.
// Included by the top level; needs signals clk and arst_n in scope.
`ifndef RLE_SPRITE_STREAM_DECODER_UNIT_ASSERT_SVH
`define RLE_SPRITE_STREAM_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RSD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rsd assertion failed");

// Next-cycle implication, checked outside reset.
`define RSD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rsd assertion failed");

`endif

>>> hw/rtl/rsd_pkg.sv
// Shared types and constants of the sprite stream decoder unit.
// No dependencies; imported by the decoder core, the top level and the testbench.
package rsd_pkg;

	localparam int AREA_W     = 25;
	localparam int COUNT_W    = 9;
	localparam int POS_W      = 32;
	localparam int RUN_W      = 14;
	localparam int OUT_ADDR_W = 24;
	localparam int COLOR_W    = 16;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 2;

	typedef enum logic [1:0] {
		OP_PALETTE = 2'd0,
		OP_START   = 2'd1,
		OP_BYTE    = 2'd2,
		OP_IGNORE  = 2'd3
	} op_t;

	localparam logic [CFG_IDX_W-1:0] REG_SURFACE_AREA  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT = 2'd1;

	localparam logic [15:0] CTRL_BLEND_BASE = 16'h4000;
	localparam logic [15:0] CTRL_END        = 16'h8000;
	localparam logic [15:0] CTRL_LONG_BASE  = 16'hC000;

	typedef struct packed {
		logic                  write_valid;
		logic                  frame_done;
		logic [OUT_ADDR_W-1:0] pixel_address;
		logic                  color_ok;
		logic                  blend_mode;
		logic [BYTE_W-1:0]     blend_factor;
	} rsd_res_t;

	typedef struct packed {
		logic               we;
		logic [BYTE_W-1:0]  waddr;
		logic [COLOR_W-1:0] wdata;
		logic               re;
		logic [BYTE_W-1:0]  raddr;
	} rsd_pal_req_t;

endpackage

>>> hw/rtl/rsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rsd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/rsd_decoder.sv
// Control-word decoder: phase, run and skip state, write position.
// Depends on rsd_pkg; drives palette RAM requests and the results for pixels and frame end.
module rsd_decoder import rsd_pkg::*; #(
	parameter int PALETTE_DEPTH = 256,
	parameter int ADDRESS_WIDTH = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_accept,
	input  logic [1:0]         operation,
	input  logic [BYTE_W-1:0]  palette_slot,
	input  logic [COLOR_W-1:0] palette_value,
	input  logic [BYTE_W-1:0]  stream_byte,
	input  logic [AREA_W-1:0]  surface_area,
	input  logic [COUNT_W-1:0] palette_count,
	output logic               res_emit,
	output rsd_res_t           res,
	output rsd_pal_req_t       pal
);

	typedef enum logic [7:0] {
		PH_ENDED     = 8'b0000_0001,
		PH_CTRL_LO   = 8'b0000_0010,
		PH_CTRL_HI   = 8'b0000_0100,
		PH_DRAW      = 8'b0000_1000,
		PH_BLEND_IDX = 8'b0001_0000,
		PH_BLEND_FAC = 8'b0010_0000,
		PH_EXTRA_LO  = 8'b0100_0000,
		PH_EXTRA_HI  = 8'b1000_0000
	} phase_t;

	localparam logic [POS_W:0]   AreaMax  = 33'(1) << ADDRESS_WIDTH;
	localparam logic [COUNT_W-1:0] DepthCnt = COUNT_W'(PALETTE_DEPTH);

	phase_t             phase_q, phase_n;
	logic [BYTE_W-1:0]  ctrl_lo_q, ctrl_lo_n;
	logic [RUN_W-1:0]   run_q, run_n;
	logic [RUN_W-1:0]   skip_hi_q, skip_hi_n;
	logic [BYTE_W-1:0]  extra_lo_q, extra_lo_n;
	logic [BYTE_W-1:0]  held_idx_q, held_idx_n;
	logic [POS_W-1:0]   pos_q, pos_n;

	logic [15:0]        ctrl;
	logic [POS_W:0]     area_ext, area_lim;
	logic [COUNT_W-1:0] cnt_lim;
	logic [29:0]        skip_adv;
	logic [POS_W:0]     skip_sum;
	logic [POS_W-1:0]   skip_pos;
	logic               skip_past;
	logic               pix_in_area;
	logic [POS_W-1:0]   pos_inc;
	logic [RUN_W-1:0]   run_dec;
	logic [BYTE_W-1:0]  pix_idx;
	logic               pix_color_ok;

	assign ctrl     = {stream_byte, ctrl_lo_q};
	assign area_ext = (POS_W+1)'(surface_area);
	assign area_lim = (area_ext > AreaMax) ? AreaMax : area_ext;
	assign cnt_lim  = (palette_count > DepthCnt) ? DepthCnt : palette_count;

	// Short skip takes the low 15 bits of the word, long skip the 30-bit assembled count.
	assign skip_adv  = (phase_q == PH_EXTRA_HI) ? {skip_hi_q, stream_byte, extra_lo_q}
	                                           : {15'd0, ctrl[14:0]};
	assign skip_sum  = {1'b0, pos_q} + (POS_W+1)'(skip_adv);
	assign skip_pos  = skip_sum[POS_W] ? '1 : skip_sum[POS_W-1:0];
	assign skip_past = {1'b0, skip_pos} >= area_lim;

	assign pix_in_area  = {1'b0, pos_q} < area_lim;
	assign pos_inc      = (&pos_q) ? pos_q : pos_q + POS_W'(1);
	assign run_dec      = run_q - RUN_W'(1);
	assign pix_idx      = (phase_q == PH_BLEND_FAC) ? held_idx_q : stream_byte;
	assign pix_color_ok = COUNT_W'(pix_idx) < cnt_lim;

	always_comb begin
		phase_n    = phase_q;
		ctrl_lo_n  = ctrl_lo_q;
		run_n      = run_q;
		skip_hi_n  = skip_hi_q;
		extra_lo_n = extra_lo_q;
		held_idx_n = held_idx_q;
		pos_n      = pos_q;
		res_emit   = 1'b0;
		res        = '0;
		pal        = '0;
		pal.waddr  = palette_slot;
		pal.wdata  = palette_value;
		pal.raddr  = pix_idx;

		if (in_accept) begin
			unique case (op_t'(operation))
				OP_PALETTE: begin
					pal.we = COUNT_W'(palette_slot) < DepthCnt;
				end
				OP_START: begin
					pos_n   = '0;
					run_n   = '0;
					phase_n = PH_CTRL_LO;
				end
				OP_BYTE: begin
					unique case (phase_q)
						PH_ENDED: begin
						end
						PH_CTRL_LO: begin
							ctrl_lo_n = stream_byte;
							phase_n   = PH_CTRL_HI;
						end
						PH_CTRL_HI: begin
							priority if (ctrl == 16'd0) begin
								phase_n = PH_CTRL_LO;
							end else if (ctrl < CTRL_BLEND_BASE) begin
								run_n   = ctrl[RUN_W-1:0];
								phase_n = PH_DRAW;
							end else if (ctrl < CTRL_END) begin
								run_n   = ctrl[RUN_W-1:0];
								phase_n = (ctrl[RUN_W-1:0] != '0) ? PH_BLEND_IDX : PH_CTRL_LO;
							end else if (ctrl == CTRL_END) begin
								phase_n        = PH_ENDED;
								run_n          = '0;
								res_emit       = 1'b1;
								res.frame_done = 1'b1;
							end else if (ctrl < CTRL_LONG_BASE) begin
								pos_n = skip_pos;
								if (skip_past) begin
									phase_n        = PH_ENDED;
									run_n          = '0;
									res_emit       = 1'b1;
									res.frame_done = 1'b1;
								end else begin
									phase_n = PH_CTRL_LO;
								end
							end else begin
								skip_hi_n = ctrl[RUN_W-1:0];
								phase_n   = PH_EXTRA_LO;
							end
						end
						PH_DRAW: begin
							res_emit          = pix_in_area;
							res.write_valid   = 1'b1;
							res.pixel_address = pos_q[OUT_ADDR_W-1:0];
							res.color_ok      = pix_color_ok;
							pal.re            = pix_in_area && pix_color_ok;
							pos_n             = pos_inc;
							run_n             = run_dec;
							if (run_dec == '0) begin
								phase_n = PH_CTRL_LO;
							end
						end
						PH_BLEND_IDX: begin
							held_idx_n = stream_byte;
							phase_n    = PH_BLEND_FAC;
						end
						PH_BLEND_FAC: begin
							res_emit          = pix_in_area;
							res.write_valid   = 1'b1;
							res.pixel_address = pos_q[OUT_ADDR_W-1:0];
							res.color_ok      = pix_color_ok;
							res.blend_mode    = 1'b1;
							res.blend_factor  = stream_byte;
							pal.re            = pix_in_area && pix_color_ok;
							pos_n             = pos_inc;
							run_n             = run_dec;
							phase_n           = (run_dec != '0) ? PH_BLEND_IDX : PH_CTRL_LO;
						end
						PH_EXTRA_LO: begin
							extra_lo_n = stream_byte;
							phase_n    = PH_EXTRA_HI;
						end
						PH_EXTRA_HI: begin
							pos_n = skip_pos;
							if (skip_past) begin
								phase_n        = PH_ENDED;
								run_n          = '0;
								res_emit       = 1'b1;
								res.frame_done = 1'b1;
							end else begin
								phase_n = PH_CTRL_LO;
							end
						end
						default: begin
						end
					endcase
				end
				OP_IGNORE: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_ENDED;
			ctrl_lo_q  <= '0;
			run_q      <= '0;
			skip_hi_q  <= '0;
			extra_lo_q <= '0;
			held_idx_q <= '0;
			pos_q      <= '0;
		end else begin
			phase_q    <= phase_n;
			ctrl_lo_q  <= ctrl_lo_n;
			run_q      <= run_n;
			skip_hi_q  <= skip_hi_n;
			extra_lo_q <= extra_lo_n;
			held_idx_q <= held_idx_n;
			pos_q      <= pos_n;
		end
	end

endmodule

>>> hw/rtl/rle_sprite_stream_decoder_unit.sv
// Top level of the run-length sprite stream decoder unit.
// Depends on rsd_pkg, rsd_ram, rsd_decoder and the assertion macro header.
//
// Usage:
//  Input stream (s_*): tuser carries the operation (palette write, start frame,
//  stream byte, ignore); tdata carries palette slot, palette value and stream byte.
//  Output stream (m_*): one transfer per drawn or blended pixel inside the
//  surface, and one transfer with tlast high when the frame ends (end word, or
//  a skip landing at or past the surface area). tuser high marks a pixel write.
//  Config channel (cfg_*): index 0 writes the surface area, index 1 the palette
//  count; always ready, to be written only while the unit is idle.
// Timing:
//  One input item per cycle while s_tready is high. A result leaves through the
//  pending register and then the output register: the pending result is held
//  while the palette RAM read completes, then the colour is merged into the output
//  register.
// Reset: decoder waits for a start frame; area resets to 0, palette count to
//  256. Palette contents are undefined until written.
// Stall: with the output register full and m_tready low, the pending stage
//  holds and s_tready drops; it rises again in the cycle the output drains.
`include "rle_sprite_stream_decoder_unit_assert.svh"

module rle_sprite_stream_decoder_unit import rsd_pkg::*; #(
	parameter int PALETTE_DEPTH = 256,
	parameter int ADDRESS_WIDTH = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [7:0] palette_slot, [23:8] palette_value, [31:24] stream_byte
	input  logic [31:0]          s_tdata,
	// [1:0] operation
	input  logic [1:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [23:0] pixel_address, [39:24] pixel_color, [40] blend_mode,
	// [48:41] blend_factor, [55:49] zero
	output logic [55:0]          m_tdata,
	// [0] write_valid
	output logic                 m_tuser,
	output logic                 m_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [AREA_W-1:0]    cfg_data
);

	localparam int PalAw = $clog2(PALETTE_DEPTH);

	logic [AREA_W-1:0]  surface_area_q;
	logic [COUNT_W-1:0] palette_count_q;

	logic               in_accept;
	logic               out_free;
	logic               s1_adv;
	logic               res_emit;
	rsd_res_t           res;
	rsd_pal_req_t       pal;
	logic [COLOR_W-1:0] pal_rdata;

	logic               s1_valid_q;
	rsd_res_t           res_s1;
	logic               out_valid_q;
	rsd_res_t           out_res_q;
	logic [COLOR_W-1:0] out_color_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			surface_area_q  <= '0;
			palette_count_q <= COUNT_W'(256);
		end else if (cfg_valid) begin
			if (cfg_index == REG_SURFACE_AREA) begin
				surface_area_q <= cfg_data;
			end else if (cfg_index == REG_PALETTE_COUNT) begin
				palette_count_q <= cfg_data[COUNT_W-1:0];
			end
		end
	end

	assign out_free  = !out_valid_q || m_tready;
	assign s1_adv    = s1_valid_q && out_free;
	assign s_tready  = !s1_valid_q || out_free;
	assign in_accept = s_tvalid && s_tready;

	rsd_decoder #(
		.PALETTE_DEPTH(PALETTE_DEPTH),
		.ADDRESS_WIDTH(ADDRESS_WIDTH)
	) u_decoder (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_accept    (in_accept),
		.operation    (s_tuser),
		.palette_slot (s_tdata[7:0]),
		.palette_value(s_tdata[23:8]),
		.stream_byte  (s_tdata[31:24]),
		.surface_area (surface_area_q),
		.palette_count(palette_count_q),
		.res_emit     (res_emit),
		.res          (res),
		.pal          (pal)
	);

	rsd_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk  (clk),
		.we   (pal.we),
		.waddr(pal.waddr[PalAw-1:0]),
		.wdata(pal.wdata),
		.re   (pal.re),
		.raddr(pal.raddr[PalAw-1:0]),
		.rdata(pal_rdata)
	);

	// Pending result waits here for the palette read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= res_emit;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_s1 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_res_q   <= res_s1;
			out_color_q <= res_s1.color_ok ? pal_rdata : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_res_q.write_valid;
	assign m_tlast  = out_res_q.frame_done;
	assign m_tdata  = {7'd0, out_res_q.blend_factor, out_res_q.blend_mode, out_color_q,
	                   out_res_q.pixel_address};

	`RSD_ASSERT_IMP(a_hold_when_full, s1_valid_q && !out_free, !s_tready)
	`RSD_ASSERT_NEXT(a_pending_moves_out, s1_valid_q && out_free, m_tvalid)
	`RSD_ASSERT_IMP(a_done_not_write, m_tvalid && m_tlast, !m_tuser)
	`RSD_ASSERT_IMP(a_blend_is_write, m_tvalid && m_tdata[40], m_tuser && !m_tlast)

endmodule

>>> tb/rsd_result_checker.sv
// Result checker for the sprite stream decoder testbench.
// Mirrors the decoder from the observed input and config transfers and compares
// every output transfer in order. Depends on rsd_pkg.
module rsd_result_checker import rsd_pkg::*; #(
	parameter int PALETTE_DEPTH = 256,
	parameter int ADDRESS_WIDTH = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [31:0]          s_tdata,
	input  logic [1:0]           s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [55:0]          m_tdata,
	input  logic                 m_tuser,
	input  logic                 m_tlast,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [AREA_W-1:0]    cfg_data,
	output int                   fail_count,
	output int                   pending
);

	typedef enum logic [2:0] {
		DEC_ENDED,
		DEC_CTRL_LO,
		DEC_CTRL_HI,
		DEC_DRAW,
		DEC_BLEND_IDX,
		DEC_BLEND_FAC,
		DEC_EXTRA_LO,
		DEC_EXTRA_HI
	} decode_phase_e;

	typedef struct packed {
		logic                  write_valid;
		logic [OUT_ADDR_W-1:0] address;
		logic [COLOR_W-1:0]    color;
		logic                  blend;
		logic [BYTE_W-1:0]     factor;
		logic                  done;
	} sprite_result_t;

	logic [AREA_W-1:0]  area_reg;
	logic [COUNT_W-1:0] count_reg;
	decode_phase_e      phase;
	logic [BYTE_W-1:0]  ctrl_low;
	logic [BYTE_W-1:0]  extra_low;
	logic [BYTE_W-1:0]  held_index;
	logic [RUN_W-1:0]   run_left;
	logic [RUN_W-1:0]   skip_high;
	logic [POS_W-1:0]   position;
	logic [COLOR_W-1:0] palette_mirror [PALETTE_DEPTH];
	sprite_result_t     awaited_results [$];

	function automatic logic [63:0] area_limit();
		logic [63:0] cap;
		cap = 64'd1 << ADDRESS_WIDTH;
		return (64'(area_reg) > cap) ? cap : 64'(area_reg);
	endfunction

	function automatic logic [COLOR_W-1:0] palette_color(logic [BYTE_W-1:0] idx);
		int usable;
		usable = (count_reg > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(count_reg);
		return (int'(idx) >= usable) ? '0 : palette_mirror[idx];
	endfunction

	function automatic void close_frame();
		sprite_result_t res;
		res = '0;
		res.done = 1'b1;
		phase = DEC_ENDED;
		run_left = '0;
		awaited_results = {awaited_results, res};
	endfunction

	// Write only inside the area, but advance the position for every pixel.
	function automatic void emit_pixel(logic [BYTE_W-1:0] idx, logic blend,
			logic [BYTE_W-1:0] factor);
		sprite_result_t res;
		if (64'(position) < area_limit()) begin
			res.write_valid = 1'b1;
			res.address = position[OUT_ADDR_W-1:0];
			res.color = palette_color(idx);
			res.blend = blend;
			res.factor = factor;
			res.done = 1'b0;
			awaited_results = {awaited_results, res};
		end
		if (position != '1)
			position++;
	endfunction

	function automatic void skip_ahead(logic [63:0] advance);
		logic [63:0] target;
		target = 64'(position) + advance;
		if (target > 64'hFFFF_FFFF)
			target = 64'hFFFF_FFFF;
		position = target[POS_W-1:0];
		if (target >= area_limit())
			close_frame();
		else
			phase = DEC_CTRL_LO;
	endfunction

	function automatic void decode_transfer(op_t op, logic [31:0] data);
		logic [BYTE_W-1:0]  slot;
		logic [COLOR_W-1:0] value;
		logic [BYTE_W-1:0]  b;
		logic [15:0]        ctrl;
		slot = data[7:0];
		value = data[23:8];
		b = data[31:24];
		case (op)
			OP_PALETTE: begin
				if (int'(slot) < PALETTE_DEPTH)
					palette_mirror[slot] = value;
			end
			OP_START: begin
				position = '0;
				run_left = '0;
				phase = DEC_CTRL_LO;
			end
			OP_BYTE: begin
				case (phase)
					DEC_CTRL_LO: begin
						ctrl_low = b;
						phase = DEC_CTRL_HI;
					end
					DEC_CTRL_HI: begin
						ctrl = {b, ctrl_low};
						if (ctrl == '0) begin
							phase = DEC_CTRL_LO;
						end else if (ctrl < CTRL_BLEND_BASE) begin
							run_left = ctrl[RUN_W-1:0];
							phase = DEC_DRAW;
						end else if (ctrl < CTRL_END) begin
							run_left = ctrl[RUN_W-1:0];
							phase = (run_left != '0) ? DEC_BLEND_IDX : DEC_CTRL_LO;
						end else if (ctrl == CTRL_END) begin
							close_frame();
						end else if (ctrl < CTRL_LONG_BASE) begin
							skip_ahead(64'(ctrl[14:0]));
						end else begin
							skip_high = ctrl[RUN_W-1:0];
							phase = DEC_EXTRA_LO;
						end
					end
					DEC_DRAW: begin
						emit_pixel(b, 1'b0, '0);
						run_left--;
						if (run_left == '0)
							phase = DEC_CTRL_LO;
					end
					DEC_BLEND_IDX: begin
						held_index = b;
						phase = DEC_BLEND_FAC;
					end
					DEC_BLEND_FAC: begin
						emit_pixel(held_index, 1'b1, b);
						run_left--;
						phase = (run_left != '0) ? DEC_BLEND_IDX : DEC_CTRL_LO;
					end
					DEC_EXTRA_LO: begin
						extra_low = b;
						phase = DEC_EXTRA_HI;
					end
					DEC_EXTRA_HI: begin
						skip_ahead({34'd0, skip_high, b, extra_low});
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string what, sprite_result_t got, sprite_result_t want);
		if (fail_count < 40)
			$display("%0t %s: got v%0d a%h c%h m%0d f%h d%0d, expected v%0d a%h c%h m%0d f%h d%0d",
				$time, what, got.write_valid, got.address, got.color, got.blend, got.factor,
				got.done, want.write_valid, want.address, want.color, want.blend,
				want.factor, want.done);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		sprite_result_t got;
		sprite_result_t want;
		if (!arst_n) begin
			area_reg = '0;
			count_reg = 9'd256;
			phase = DEC_ENDED;
			ctrl_low = '0;
			extra_low = '0;
			held_index = '0;
			run_left = '0;
			skip_high = '0;
			position = '0;
			awaited_results.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			// Compare first: a result never leaves in the cycle of its input transfer.
			if (m_tvalid && m_tready) begin
				got.write_valid = m_tuser;
				got.address = m_tdata[23:0];
				got.color = m_tdata[39:24];
				got.blend = m_tdata[40];
				got.factor = m_tdata[48:41];
				got.done = m_tlast;
				if (awaited_results.size() == 0) begin
					report_mismatch("result with none expected", got, '0);
				end else begin
					want = awaited_results.pop_front();
					if (got.write_valid !== want.write_valid || got.address !== want.address
							|| got.color !== want.color || got.blend !== want.blend
							|| got.factor !== want.factor || got.done !== want.done
							|| m_tdata[55:49] !== '0)
						report_mismatch("wrong result", got, want);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SURFACE_AREA: area_reg = cfg_data;
					REG_PALETTE_COUNT: count_reg = cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				decode_transfer(op_t'(s_tuser), s_tdata);
			pending <= awaited_results.size();
		end
	end

endmodule

>>> tb/tb_top.sv
// Top of the sprite stream decoder testbench: clock, reset, stimulus and verdict.
// Depends on rsd_pkg, rle_sprite_stream_decoder_unit and rsd_result_checker.
module tb_top;
	import rsd_pkg::*;

	localparam int PALETTE_DEPTH = 256;
	localparam int ADDRESS_WIDTH = 24;
	localparam int CYCLE_LIMIT   = 400000;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [15:0]          CTRL_NOP   = 16'h0000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [31:0]          s_tdata = '0;
	logic [1:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [55:0]          m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [AREA_W-1:0]    cfg_data = '0;
	int                   fail_count;
	int                   pending;

	int   cycle_count = 0;
	int   sent_items = 0;
	logic tx_quiet = 1'b0;
	logic rx_quiet = 1'b0;
	int   rx_hold = 0;
	int   rx_draw;

	rle_sprite_stream_decoder_unit #(
		.PALETTE_DEPTH(PALETTE_DEPTH),
		.ADDRESS_WIDTH(ADDRESS_WIDTH)
	) dut (.*);

	rsd_result_checker #(
		.PALETTE_DEPTH(PALETTE_DEPTH),
		.ADDRESS_WIDTH(ADDRESS_WIDTH)
	) u_checker (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// After some output transfers, drop ready for a random number of cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_hold <= 0;
		end else if (rx_hold > 1) begin
			rx_hold <= rx_hold - 1;
		end else if (rx_hold == 1) begin
			rx_hold <= 0;
			m_tready <= 1'b1;
		end else if (!m_tready) begin
			m_tready <= 1'b1;
		end else if (m_tvalid) begin
			if ($urandom_range(0, 49) == 0)
				rx_quiet <= !rx_quiet;
			rx_draw = rx_quiet ? 0 : $urandom_range(0, 10);
			if (rx_draw != 0) begin
				m_tready <= 1'b0;
				rx_hold <= rx_draw;
			end
		end
	end

	task automatic put_item(op_t op, logic [7:0] slot, logic [15:0] value, logic [7:0] data_byte);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {data_byte, value, slot};
		do @(posedge clk); while (!s_tready);
		if (op != OP_IGNORE)
			sent_items++;
	endtask

	task automatic put_byte(logic [7:0] b);
		put_item(OP_BYTE, 8'($urandom), 16'($urandom), b);
	endtask

	task automatic put_word(logic [15:0] w);
		put_byte(w[7:0]);
		put_byte(w[15:8]);
	endtask

	task automatic start_frame();
		put_item(OP_START, 8'($urandom), 16'($urandom), 8'($urandom));
	endtask

	// Leaves valid high; the caller lowers it after the last write.
	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [AREA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_setting(logic [AREA_W-1:0] area, logic [COUNT_W-1:0] count);
		set_reg(REG_SURFACE_AREA, area);
		set_reg(REG_PALETTE_COUNT, AREA_W'(count));
		cfg_valid <= 1'b0;
	endtask

	// Drain all awaited results, then give the pipeline time to empty.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic noise_item();
		case ($urandom_range(0, 4))
			0: put_item(OP_IGNORE, 8'($urandom), 16'($urandom), 8'($urandom));
			1: put_item(OP_PALETTE, 8'($urandom), 16'($urandom), 8'($urandom));
			2: start_frame();
			default: put_byte(8'($urandom));
		endcase
	endtask

	task automatic random_frame(logic big_area);
		int          cmds;
		int          pick;
		int          n;
		logic [15:0] high_part;
		cmds = $urandom_range(1, 12);
		start_frame();
		repeat (cmds) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
				put_word(16'(n));
				repeat (n) put_byte(8'($urandom));
			end else if (pick < 60) begin
				n = $urandom_range(0, 6);
				put_word(CTRL_BLEND_BASE | 16'(n));
				repeat (n) begin
					put_byte(8'($urandom));
					put_byte(8'($urandom));
				end
			end else if (pick < 66) begin
				put_word(CTRL_NOP);
			end else if (pick < 78) begin
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16'h7FFF)
					: $urandom_range(1, 40);
				put_word(CTRL_END | 16'(n));
			end else if (pick < 86) begin
				if (big_area)
					high_part = 16'($urandom_range(0, 255));
				else if ($urandom_range(0, 7) == 0)
					high_part = 16'($urandom_range(0, 16'h3FFF));
				else
					high_part = '0;
				put_word(CTRL_LONG_BASE | high_part);
				put_word(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)));
			end else if (pick < 94) begin
				noise_item();
			end
		end
		// Most frames close with an end word; the rest are abandoned by the next start.
		if ($urandom_range(0, 9) != 0)
			put_word(CTRL_END);
	endtask

	task automatic run_phase(logic [AREA_W-1:0] area, logic [COUNT_W-1:0] count, int budget);
		int target;
		apply_setting(area, count);
		target = sent_items + budget;
		while (sent_items < target) begin
			if ($urandom_range(0, 3) == 0)
				tx_quiet = !tx_quiet;
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, 4)) noise_item();
			random_frame(area > 65536);
		end
		settle();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_reg(REG_UNUSED, AREA_W'($urandom));
		apply_setting(25'd400, 9'd200);

		// Fill every palette entry so that no index can hit an unwritten one.
		for (int slot = 0; slot < PALETTE_DEPTH; slot++)
			put_item(OP_PALETTE, 8'(slot),
				(slot == 0) ? 16'hFFFF : (slot == 1) ? 16'h0000 : 16'($urandom),
				8'($urandom));

		start_frame();
		put_word(16'd3);
		put_byte(8'd0);
		put_byte(8'd200);
		put_byte(8'd255);
		put_word(CTRL_NOP);
		put_word(CTRL_BLEND_BASE);
		put_word(CTRL_BLEND_BASE | 16'd1);
		put_byte(8'd199);
		put_byte(8'hFF);
		put_word(CTRL_END | 16'd1);
		put_word(CTRL_END);
		put_byte(8'hA5);
		put_item(OP_IGNORE, 8'hFF, 16'hFFFF, 8'hFF);
		start_frame();
		put_word(16'h3FFF);
		start_frame();
		put_word(16'h7FFF);
		start_frame();
		put_word(16'hFFFF);
		put_word(16'hFFFF);
		settle();

		run_phase(25'd0, 9'd0, 100);
		run_phase(25'd16777216, 9'd256, 300);
		run_phase(25'd1, 9'd1, 100);
		repeat (3)
			run_phase(25'($urandom_range(64, 3000)), 9'($urandom_range(1, 255)), 300);

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
